// ===== rtl/core/lrmc_pkg.sv =====
// ============================================================================
// lrmc_pkg: shared definitions of the lag ring multiply-with-carry generator
// Widths, reset values, codes and the carry step result type.
// ============================================================================
package lrmc_pkg;

  localparam int LAG_LENGTH = 2048;
  localparam int PTR_W      = $clog2(LAG_LENGTH);
  localparam int IDX_W      = 11;
  localparam int WORD_W     = 32;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CARRY_W    = 21;
  localparam int PROD_W     = CFG_W + WORD_W;

  localparam logic [WORD_W-1:0] WORD_BASE         = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] WORD_TOP          = 32'hFFFF_FFFD;
  localparam logic [CFG_W-1:0]  MULT_RESET        = 20'd1047570;
  localparam logic [CFG_W-1:0]  START_CARRY_RESET = 20'd123;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_DRAW = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULTIPLIER  = 1'b0,
    CFG_START_CARRY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [CARRY_W-1:0] carry;
  } step_t;

endpackage

// ===== rtl/core/lrmc_if.sv =====
// ============================================================================
// lrmc_if: channel interfaces of the generator
// Valid/ready channels for input items and for result words.
// ============================================================================
interface lrmc_in_if;
  import lrmc_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  seed_index;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output mode, output seed_index, output seed_value,
                  input ready);
  modport sink   (input valid, input mode, input seed_index, input seed_value,
                  output ready);
endinterface

interface lrmc_out_if;
  import lrmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ===== rtl/core/lag_ring_multiply_carry_generator.sv =====
// ============================================================================
// lag_ring_multiply_carry_generator: lag ring multiply-with-carry generator
// Complementary multiply-with-carry over a ring of 32-bit lag words.
// ============================================================================
// Items arrive on in_ch. A load transaction stores its seed with bit 0
// cleared at seed_index, restores the carry to start_carry and rewinds the
// draw pointer; it gives no result. A draw transaction multiplies the ring
// word at the pointer by the multiplier register, adds the carry, writes the new word
// back, advances the pointer and delivers the word on out_ch.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, as the
// block itself does not enforce it. One item is accepted per cycle while
// in_ch.ready is high. A draw passes both stages into the output register.
// The rate is set by the single ring memory port pair: one read at
// acceptance, one write two stages later, with forwarding of recent writes.
// The whole ring must be loaded before the first draw. Reset clears the
// pipeline, sets the pointer to zero, the carry and the registers to their
// reset values; the ring itself is not cleared.
// When the receiver stalls with a draw waiting behind a full output register,
// the pipeline holds and in_ch.ready falls; loads and bubbles keep moving.
// ============================================================================
module lag_ring_multiply_carry_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  lrmc_in_if.sink                       in_ch,
  lrmc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lrmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrmc_pkg::CFG_W-1:0]    cfg_wdata
);
  import lrmc_pkg::*;

  logic [CFG_W-1:0]   mult_r;
  logic [CFG_W-1:0]   start_carry_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   ptr_nxt;
  logic [CARRY_W-1:0] carry_r;

  logic [WORD_W-1:0]  ring_mem [LAG_LENGTH];
  logic [WORD_W-1:0]  rd_data_r;

  logic               s1_valid_r;
  logic               s1_draw_r;
  logic               s1_wen_r;
  logic [PTR_W-1:0]   s1_addr_r;
  logic [WORD_W-1:0]  s1_seed_r;
  logic [WORD_W-1:0]  s1_word;
  logic [PROD_W-1:0]  s1_prod;

  logic               s2_valid_r;
  logic               s2_draw_r;
  logic               s2_wen_r;
  logic [PTR_W-1:0]   s2_addr_r;
  logic [WORD_W-1:0]  s2_seed_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic [WORD_W-1:0]  s2_wdata;
  logic               s2_write;
  step_t              step;

  logic               wr_valid_r;
  logic [PTR_W-1:0]   wr_addr_r;
  logic [WORD_W-1:0]  wr_data_r;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_data_r;

  logic               adv;
  logic               in_accept;
  logic               in_draw;
  logic               in_wen;
  logic [PTR_W-1:0]   in_addr;

  assign adv       = !(s2_valid_r && s2_draw_r) || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_accept = in_ch.valid && adv;
  assign in_draw   = (in_ch.mode == MODE_DRAW);
  assign in_wen    = in_draw || ({{(32-IDX_W){1'b0}}, in_ch.seed_index} < 32'(LAG_LENGTH));
  assign in_addr   = in_draw ? ptr_r : PTR_W'(in_ch.seed_index);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_data_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_accept) begin
      if (!in_draw) begin
        ptr_nxt = '0;
      end else if (ptr_r == PTR_W'(LAG_LENGTH - 1)) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r        <= MULT_RESET;
      start_carry_r <= START_CARRY_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MULTIPLIER:  mult_r        <= cfg_wdata;
        CFG_START_CARRY: start_carry_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= ring_mem[ptr_r];
    end
    if (adv && s2_write) begin
      ring_mem[s2_addr_r] <= s2_wdata;
    end
  end

  // A load still in the second stage, or the write made at the edge of the
  // read, is not yet visible in the registered read data.
  always_comb begin
    s1_word = rd_data_r;
    if (s2_valid_r && !s2_draw_r && s2_wen_r && (s2_addr_r == s1_addr_r)) begin
      s1_word = s2_seed_r;
    end else if (wr_valid_r && (wr_addr_r == s1_addr_r)) begin
      s1_word = wr_data_r;
    end
  end

  assign s1_prod = PROD_W'(mult_r) * PROD_W'(s1_word);

  lrmc_carry_step u_step (
    .prod  (s2_prod_r),
    .carry (carry_r),
    .res   (step)
  );

  assign s2_wdata = s2_draw_r ? step.word : s2_seed_r;
  assign s2_write = s2_valid_r && s2_wen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      carry_r     <= CARRY_W'(START_CARRY_RESET);
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (adv) begin
        s1_valid_r <= in_accept;
        s2_valid_r <= s1_valid_r;
        wr_valid_r <= s2_write;
        if (s2_valid_r) begin
          carry_r <= s2_draw_r ? step.carry : CARRY_W'(start_carry_r);
        end
      end
      if (adv && s2_valid_r && s2_draw_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_draw_r <= in_draw;
      s1_wen_r  <= in_wen;
      s1_addr_r <= in_addr;
      s1_seed_r <= in_ch.seed_value & WORD_BASE;
      s2_draw_r <= s1_draw_r;
      s2_wen_r  <= s1_wen_r;
      s2_addr_r <= s1_addr_r;
      s2_seed_r <= s1_seed_r;
      s2_prod_r <= s1_prod;
      wr_addr_r <= s2_addr_r;
      wr_data_r <= s2_wdata;
      if (s2_valid_r && s2_draw_r) begin
        out_data_r <= step.word;
      end
    end
  end

  a_load_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_draw) |=> (ptr_r == '0))
    else $error("pointer not rewound after a load transaction");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ptr_r) < 32'(LAG_LENGTH)))
    else $error("draw pointer outside the ring");

  a_load_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && !s2_draw_r) |=> (carry_r == CARRY_W'($past(start_carry_r))))
    else $error("carry not restored by a load transaction");

  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_draw_r) |=> (out_valid_r && (out_data_r == $past(step.word))))
    else $error("draw result not placed in the output register");

endmodule

// ===== rtl/core/lrmc_carry_step.sv =====
// ============================================================================
// lrmc_carry_step: carry recurrence of one draw
// Adds the carry to the product, divides by 0xFFFFFFFE through a fold of the
// upper half, and forms the complemented result word.
// ============================================================================
module lrmc_carry_step (
  input  logic [lrmc_pkg::PROD_W-1:0]  prod,
  input  logic [lrmc_pkg::CARRY_W-1:0] carry,
  output lrmc_pkg::step_t              res
);
  import lrmc_pkg::*;

  localparam int T_W  = PROD_W + 1;
  localparam int HI_W = T_W - WORD_W;

  logic [T_W-1:0]      t_sum;
  logic [HI_W-1:0]     t_hi;
  logic [WORD_W-1:0]   t_lo;
  logic [WORD_W:0]     fold;
  logic [HI_W-1:0]     quot;

  // Since 2^32 = base + 2, t = hi * base + (2 * hi + lo), and the folded
  // remainder stays below twice the base, so one compare finishes the division.
  assign t_sum = T_W'(prod) + T_W'(carry);
  assign t_hi  = t_sum[T_W-1:WORD_W];
  assign t_lo  = t_sum[WORD_W-1:0];
  assign fold  = (WORD_W+1)'({t_hi, 1'b0}) + (WORD_W+1)'(t_lo);
  assign quot  = (fold >= (WORD_W+1)'(WORD_BASE)) ? t_hi + HI_W'(1) : t_hi;

  assign res.word  = WORD_TOP - t_lo;
  assign res.carry = CARRY_W'(quot);

endmodule

// ===== dv/lrmc_word_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lrmc_word_checker: prediction and checking of generated words
// Watches the input, result and register write ports of the lag ring
// generator, keeps its own copy of the ring, carry and pointer, and compares
// every result transaction with the oldest predicted word.
// ============================================================================
module lrmc_word_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  lrmc_in_if                             in_ch,
  lrmc_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [lrmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrmc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             error_count,
  output int                             pending_words
);
  import lrmc_pkg::*;

  logic [WORD_W-1:0]  lag_copy [LAG_LENGTH];
  logic [CFG_W-1:0]   multiplier;
  logic [CFG_W-1:0]   restart_carry;
  logic [CARRY_W-1:0] carry;
  logic [PTR_W-1:0]   ptr;
  logic [WORD_W-1:0]  expected_words [$];

  function automatic step_t mwc_step(logic [CFG_W-1:0] mult, logic [WORD_W-1:0] lag,
                                     logic [CARRY_W-1:0] carry_in);
    logic [63:0] t;
    step_t       s;
    t = 64'(mult) * 64'(lag) + 64'(carry_in);
    s.word  = WORD_TOP - t[WORD_W-1:0];
    s.carry = CARRY_W'(t / 64'(WORD_BASE));
    return s;
  endfunction

  always @(posedge clk) begin
    step_t             s;
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      multiplier    = MULT_RESET;
      restart_carry = START_CARRY_RESET;
      carry         = CARRY_W'(START_CARRY_RESET);
      ptr           = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MULTIPLIER:  multiplier    = cfg_wdata;
          CFG_START_CARRY: restart_carry = cfg_wdata;
          default: ;
        endcase
      end
      // A draw cannot return at the edge that accepts it, so the result
      // transaction is checked before the input transaction is predicted.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("random_value: no draw pending, got %h", out_ch.random_value);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.random_value !== want) begin
            $error("random_value mismatch: expected %h, got %h", want, out_ch.random_value);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (mode_t'(in_ch.mode) == MODE_LOAD) begin
          if (int'(in_ch.seed_index) < LAG_LENGTH)
            lag_copy[in_ch.seed_index] = in_ch.seed_value & WORD_BASE;
          carry = CARRY_W'(restart_carry);
          ptr   = '0;
        end else begin
          s             = mwc_step(multiplier, lag_copy[ptr], carry);
          lag_copy[ptr] = s.word;
          carry         = s.carry;
          ptr           = PTR_W'((int'(ptr) + 1) % LAG_LENGTH);
          expected_words.push_back(s.word);
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench of the lag ring multiply-with-carry generator
// Seeds the part of the ring that the draw runs reach, runs directed loads
// and draws at the register extremes, a long draw run with no gaps, and
// random load and draw sequences under several register settings, with
// random gaps on both channels. Checking is done by lrmc_word_checker.
// ============================================================================
module tb;
  import lrmc_pkg::*;

  localparam int              STALL_LIMIT   = 2000;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              FILL_DEPTH    = 256;
  localparam int              NO_GAP_DRAWS  = 100;
  localparam int              RANDOM_ITEMS  = 1200;
  localparam int              RANDOM_PHASES = 5;
  localparam logic [CFG_W-1:0] CFG_MAX      = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               failures;
  int               pending_words;
  int               items_sent;
  int               idle_cycles = 0;
  bit               no_gaps;

  lrmc_in_if  in_bus ();
  lrmc_out_if out_bus ();

  lag_ring_multiply_carry_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lrmc_word_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_bus),
    .out_ch        (out_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (failures),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_bus.ready <= no_gaps || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] pick_seed();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic put_item(mode_t m, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    while (!no_gaps && $urandom_range(99) < 37) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= m;
    in_bus.seed_index <= idx;
    in_bus.seed_value <= val;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic draw_run(int n);
    repeat (n) put_item(MODE_DRAW, IDX_W'($urandom), $urandom);
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] mult, logic [CFG_W-1:0] start);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MULTIPLIER;
    cfg_wdata <= mult;
    @(posedge clk);
    cfg_index <= CFG_START_CARRY;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(logic [CFG_W-1:0] mult, logic [CFG_W-1:0] start,
                              bit pause_midway);
    int quota;
    bit paused = 1'b0;
    set_config(mult, start);
    quota = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
    while (items_sent < quota) begin
      if (pause_midway && !paused && items_sent >= quota - RANDOM_ITEMS / (2 * RANDOM_PHASES)) begin
        wait_for_results();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(1, 3))
          put_item(MODE_LOAD, IDX_W'($urandom_range(LAG_LENGTH - 1)), pick_seed());
        draw_run($urandom_range(1, 40));
      end else begin
        put_item(mode_t'($urandom_range(1)), IDX_W'($urandom), pick_seed());
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MULTIPLIER;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.mode       = MODE_LOAD;
    in_bus.seed_index = '0;
    in_bus.seed_value = '0;
    no_gaps           = 1'b0;
    items_sent        = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Draws restart from entry zero after every load, so only the low part
    // of the ring that the draw runs reach is seeded before the first draw.
    for (int i = 0; i < FILL_DEPTH; i++) put_item(MODE_LOAD, IDX_W'(i), pick_seed());
    wait_for_results();

    set_config(CFG_MAX, CFG_MAX);
    put_item(MODE_LOAD, IDX_W'(0), 32'hFFFF_FFFF);
    put_item(MODE_LOAD, IDX_W'(1), 32'hFFFF_FFFE);
    put_item(MODE_LOAD, IDX_W'(LAG_LENGTH - 1), 32'h0000_0001);
    put_item(MODE_LOAD, IDX_W'(2), 32'h0000_0000);
    draw_run(4);
    wait_for_results();

    set_config('0, '0);
    put_item(MODE_LOAD, IDX_W'(4), 32'h8000_0001);
    draw_run(3);
    wait_for_results();

    set_config(20'd1, CFG_MAX);
    put_item(MODE_LOAD, IDX_W'(1), 32'h7FFF_FFFF);
    draw_run(3);
    wait_for_results();

    // An unbroken draw run with no gaps on either channel.
    set_config(MULT_RESET, START_CARRY_RESET);
    no_gaps <= 1'b1;
    put_item(MODE_LOAD, IDX_W'($urandom_range(LAG_LENGTH - 1)), pick_seed());
    draw_run(NO_GAP_DRAWS);
    wait_for_results();
    no_gaps <= 1'b0;

    random_phase(CFG_W'($urandom_range(1, CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)), 1'b1);
    random_phase(CFG_MAX, '0, 1'b0);
    random_phase('0, CFG_W'($urandom_range(CFG_MAX)), 1'b0);
    random_phase(20'd1, CFG_MAX, 1'b0);
    random_phase(CFG_W'($urandom_range(1, CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)), 1'b0);

    if (pending_words != 0) $error("random_value: %0d results never arrived", pending_words);
    if (failures == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lrmc_pkg.sv
rtl/core/lrmc_if.sv
rtl/core/lrmc_carry_step.sv
rtl/core/lag_ring_multiply_carry_generator.sv
dv/lrmc_word_checker.sv
dv/tb.sv
